### hw/rtl/dkc_pkg.sv
// dkc_pkg: shared types and constants for the distinct key counter
// used by dkc_key_cam, distinct_key_counter and the testbench
// no dependencies
package dkc_pkg;

    // default sizing
    localparam int DEF_TABLE_SLOTS = 16;
    localparam int DEF_KEY_BITS    = 8;
    localparam int DEF_COUNT_BITS  = 16;

    // fixed port widths
    localparam int KEY_IN_W    = 8;
    localparam int SLOT_OUT_W  = 4;
    localparam int COUNT_OUT_W = 16;
    localparam int DIST_OUT_W  = 5;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } t_state;

    // table control from the sequencer to the key cam
    typedef struct packed {
        logic clear;
        logic insert;
    } t_cam_ctrl;

endpackage

### hw/rtl/dkc_key_cam.sv
// dkc_key_cam: key store in flip-flops with parallel compare and fill count
// depends on dkc_pkg (t_cam_ctrl)
module dkc_key_cam #(
    parameter int TABLE_SLOTS = dkc_pkg::DEF_TABLE_SLOTS,
    parameter int KEY_BITS    = dkc_pkg::DEF_KEY_BITS,
    parameter int SW          = $clog2(TABLE_SLOTS),
    parameter int UW          = $clog2(TABLE_SLOTS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dkc_pkg::t_cam_ctrl  i_ctrl,
    input  logic [KEY_BITS-1:0] i_key,
    output logic [SW-1:0]       o_hit,
    output logic                o_found,
    output logic [UW-1:0]       o_used
);

    logic [KEY_BITS-1:0] r_keys [TABLE_SLOTS];
    logic [UW-1:0]       r_used;
    logic [UW-1:0]       n_used;

    // compare against every occupied slot; stored keys are distinct so
    // at most one slot matches and the index can be or-ed together
    always_comb begin
        o_hit   = '0;
        o_found = 1'b0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if ((UW'(i) < r_used) && (r_keys[i] == i_key)) begin
                o_hit   = o_hit | SW'(i);
                o_found = 1'b1;
            end
        end
    end

    // fill count
    always_comb begin
        n_used = r_used;
        if (i_ctrl.clear) begin
            n_used = '0;
        end else if (i_ctrl.insert) begin
            n_used = r_used + UW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    // key write on insertion, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert) begin
            r_keys[r_used[SW-1:0]] <= i_key;
        end
    end

    assign o_used = r_used;

endmodule

### hw/rtl/dkc_count_ram.sv
// dkc_count_ram: synchronous count memory, one write and one read port
// registered read data; no package dependencies
module dkc_count_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/distinct_key_counter.sv
// distinct_key_counter: top level, sequencer, count update and result register
// depends on dkc_pkg, dkc_key_cam and dkc_count_ram
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+---------------------------------------------
//  keys in  | i_valid | o_ready | i_key, i_first
//  results  | o_valid | i_ready | o_slot, o_is_new, o_dropped, o_count, o_distinct
//
// each item passes through accept, cam compare with count memory read, then
// count update with memory write-back; the next item is taken the cycle after.
// one item is in flight at a time, so reads and writes to one entry never overlap.
// reset clears the fill count, sequencer and result valid; the count memory is
// not swept, as a slot's count is written on insertion before it is ever read.
// a result not yet taken holds the update stage; one more transaction is still
// taken, then the input stalls until the result is taken.
module distinct_key_counter #(
    parameter int TABLE_SLOTS = dkc_pkg::DEF_TABLE_SLOTS,
    parameter int KEY_BITS    = dkc_pkg::DEF_KEY_BITS,
    parameter int COUNT_BITS  = dkc_pkg::DEF_COUNT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [dkc_pkg::KEY_IN_W-1:0]     i_key,
    input  logic                             i_first,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [dkc_pkg::SLOT_OUT_W-1:0]   o_slot,
    output logic                             o_is_new,
    output logic                             o_dropped,
    output logic [dkc_pkg::COUNT_OUT_W-1:0]  o_count,
    output logic [dkc_pkg::DIST_OUT_W-1:0]   o_distinct
);

    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int UW = $clog2(TABLE_SLOTS + 1);
    localparam logic [UW-1:0]         SLOTS_U   = UW'(TABLE_SLOTS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    dkc_pkg::t_state    r_state;
    dkc_pkg::t_state    n_state;
    dkc_pkg::t_cam_ctrl cam_ctrl;

    logic [KEY_BITS-1:0]   r_key;
    logic [SW-1:0]         r_hit;
    logic                  r_found;
    logic [SW-1:0]         cam_hit;
    logic                  cam_found;
    logic [UW-1:0]         used;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic                  ram_we;
    logic [SW-1:0]         ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [COUNT_BITS-1:0] inc_count;
    logic                  in_accept;
    logic                  upd_fire;
    logic                  has_room;

    logic                               r_o_valid;
    logic [dkc_pkg::SLOT_OUT_W-1:0]     r_slot;
    logic                               r_is_new;
    logic                               r_dropped;
    logic [dkc_pkg::COUNT_OUT_W-1:0]    r_count;
    logic [dkc_pkg::DIST_OUT_W-1:0]     r_distinct;

    assign in_accept = i_valid && o_ready;
    assign upd_fire  = (r_state == dkc_pkg::ST_UPD) && (!r_o_valid || i_ready);
    assign has_room  = used < SLOTS_U;
    assign inc_count = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + COUNT_BITS'(1);

    // key table
    dkc_key_cam #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS),
        .SW          (SW),
        .UW          (UW)
    ) u_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cam_ctrl),
        .i_key   (r_key),
        .o_hit   (cam_hit),
        .o_found (cam_found),
        .o_used  (used)
    );

    // per-slot counts
    dkc_count_ram #(
        .DEPTH (TABLE_SLOTS),
        .WIDTH (COUNT_BITS),
        .AW    (SW)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (cam_hit),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dkc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = dkc_pkg::ST_LOOK;
                end
            end
            dkc_pkg::ST_LOOK: begin
                n_state = dkc_pkg::ST_UPD;
            end
            dkc_pkg::ST_UPD: begin
                if (upd_fire) begin
                    n_state = dkc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dkc_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs: handshake, table control and count write-back
    always_comb begin
        o_ready         = 1'b0;
        cam_ctrl.clear  = 1'b0;
        cam_ctrl.insert = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = r_hit;
        ram_wdata       = inc_count;
        case (r_state)
            dkc_pkg::ST_IDLE: begin
                o_ready        = 1'b1;
                cam_ctrl.clear = in_accept && i_first;
            end
            dkc_pkg::ST_LOOK: begin
            end
            dkc_pkg::ST_UPD: begin
                if (upd_fire) begin
                    if (r_found) begin
                        ram_we = 1'b1;
                    end else if (has_room) begin
                        cam_ctrl.insert = 1'b1;
                        ram_we          = 1'b1;
                        ram_waddr       = used[SW-1:0];
                        ram_wdata       = COUNT_BITS'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dkc_pkg::ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (upd_fire) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // input capture and lookup result
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_key <= KEY_BITS'(i_key);
        end
        if (r_state == dkc_pkg::ST_LOOK) begin
            r_hit   <= cam_hit;
            r_found <= cam_found;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            if (r_found) begin
                r_slot     <= dkc_pkg::SLOT_OUT_W'(r_hit);
                r_is_new   <= 1'b0;
                r_dropped  <= 1'b0;
                r_count    <= dkc_pkg::COUNT_OUT_W'(inc_count);
                r_distinct <= dkc_pkg::DIST_OUT_W'(used);
            end else if (has_room) begin
                r_slot     <= dkc_pkg::SLOT_OUT_W'(used);
                r_is_new   <= 1'b1;
                r_dropped  <= 1'b0;
                r_count    <= dkc_pkg::COUNT_OUT_W'(1);
                r_distinct <= dkc_pkg::DIST_OUT_W'(used + UW'(1));
            end else begin
                r_slot     <= '0;
                r_is_new   <= 1'b0;
                r_dropped  <= 1'b1;
                r_count    <= '0;
                r_distinct <= dkc_pkg::DIST_OUT_W'(used);
            end
        end
    end

    assign o_valid    = r_o_valid;
    assign o_slot     = r_slot;
    assign o_is_new   = r_is_new;
    assign o_dropped  = r_dropped;
    assign o_count    = r_count;
    assign o_distinct = r_distinct;

`ifndef SYNTH
    // fill count never exceeds the table
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used <= SLOTS_U)
        else $error("fill count beyond table size");

    // a first-flag transaction empties the table before lookup
    a_first_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_first) |=> (used == '0))
        else $error("table not cleared by first flag");

    // an insertion produces a new-key result with a count of one
    a_insert_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cam_ctrl.insert |=> (o_valid && o_is_new && !o_dropped && (o_count == 1)))
        else $error("insertion result mismatch");

    // a dropped key leaves the table full and stores nothing
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd_fire && !r_found && !has_room) |-> (!ram_we && !cam_ctrl.insert))
        else $error("dropped key modified the table");

    // a result waiting to be taken holds the update stage
    a_upd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == dkc_pkg::ST_UPD) && r_o_valid && !i_ready) |=>
            (r_state == dkc_pkg::ST_UPD))
        else $error("update stage overran a pending result");
`endif

endmodule

### test/tb.sv
// tb: self-checking testbench for distinct_key_counter
// keeps its own copy of the key table to predict every result
// depends on dkc_pkg and distinct_key_counter
`timescale 1ns / 100ps

module tb;

    localparam int N_SLOTS   = dkc_pkg::DEF_TABLE_SLOTS;
    localparam int COUNT_TOP = (1 << dkc_pkg::DEF_COUNT_BITS) - 1;

    // one predicted result transaction
    typedef struct packed {
        logic [dkc_pkg::SLOT_OUT_W-1:0]  slot;
        logic                            is_new;
        logic                            dropped;
        logic [dkc_pkg::COUNT_OUT_W-1:0] count;
        logic [dkc_pkg::DIST_OUT_W-1:0]  distinct;
    } t_key_result;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_ready;
    logic [dkc_pkg::KEY_IN_W-1:0]    i_key;
    logic                            i_first;
    logic                            o_valid;
    logic                            i_ready;
    logic [dkc_pkg::SLOT_OUT_W-1:0]  o_slot;
    logic                            o_is_new;
    logic                            o_dropped;
    logic [dkc_pkg::COUNT_OUT_W-1:0] o_count;
    logic [dkc_pkg::DIST_OUT_W-1:0]  o_distinct;

    // predicted table contents
    logic [dkc_pkg::DEF_KEY_BITS-1:0]   seen_keys [N_SLOTS];
    logic [dkc_pkg::DEF_COUNT_BITS-1:0] key_counts[N_SLOTS];
    int                                 keys_held;

    t_key_result pending_results[$];
    int          mismatch_count;
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          hold_request;

    distinct_key_counter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_key      (i_key),
        .i_first    (i_first),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_slot     (o_slot),
        .o_is_new   (o_is_new),
        .o_dropped  (o_dropped),
        .o_count    (o_count),
        .o_distinct (o_distinct)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("** distinct_key_counter: FAILED **");
        $finish;
    end

    // table lookup, insertion and count update for one key
    function automatic t_key_result tally_key(input logic [dkc_pkg::KEY_IN_W-1:0] key,
                                              input logic first);
        t_key_result r;
        int          hit;
        r   = '0;
        hit = -1;
        if (first) begin
            keys_held = 0;
            foreach (key_counts[i]) key_counts[i] = '0;
        end
        for (int i = 0; i < keys_held; i++) begin
            if (hit < 0 && seen_keys[i] == key[dkc_pkg::DEF_KEY_BITS-1:0]) hit = i;
        end
        if (hit >= 0) begin
            if (key_counts[hit] != COUNT_TOP[dkc_pkg::DEF_COUNT_BITS-1:0])
                key_counts[hit] = key_counts[hit] + 1'b1;
        end else if (keys_held < N_SLOTS) begin
            hit             = keys_held;
            seen_keys[hit]  = key[dkc_pkg::DEF_KEY_BITS-1:0];
            key_counts[hit] = dkc_pkg::DEF_COUNT_BITS'(1);
            keys_held++;
            r.is_new = 1'b1;
        end else begin
            // table full: key is dropped, nothing stored
            r.dropped  = 1'b1;
            r.distinct = keys_held[dkc_pkg::DIST_OUT_W-1:0];
            return r;
        end
        r.slot     = hit[dkc_pkg::SLOT_OUT_W-1:0];
        r.count    = key_counts[hit][dkc_pkg::COUNT_OUT_W-1:0];
        r.distinct = keys_held[dkc_pkg::DIST_OUT_W-1:0];
        return r;
    endfunction

    // offer one key transaction, with a random idle gap first
    task automatic offer_key(input logic [dkc_pkg::KEY_IN_W-1:0] key, input logic first);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid <= 1'b1;
        i_key   <= key;
        i_first <= first;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(tally_key(key, first));
    endtask

    // sender pauses until every predicted result has been seen
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stalls, plus long hold-offs on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // compare each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_key_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, actual slot %0d count %0d",
                         $time, o_slot, o_count);
                mismatch_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("slot", exp_r.slot, o_slot);
                check_field("is_new", exp_r.is_new, o_is_new);
                check_field("dropped", exp_r.dropped, o_dropped);
                check_field("count", exp_r.count, o_count);
                check_field("distinct", exp_r.distinct, o_distinct);
            end
        end
    end

    // edge keys, clearing, filling the table and overflowing it
    task automatic test_directed();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        offer_key(8'h00, 1'b0);
        offer_key(8'hFF, 1'b0);
        offer_key(8'h00, 1'b0);
        offer_key(8'hAA, 1'b0);
        offer_key(8'h55, 1'b0);
        // clear then fill all slots
        offer_key(8'h00, 1'b1);
        for (int k = 1; k < N_SLOTS; k++) offer_key(8'(k), 1'b0);
        // new key with table full
        offer_key(8'd200, 1'b0);
        offer_key(8'd15, 1'b0);
        // clear while full
        offer_key(8'd200, 1'b1);
        offer_key(8'hFF, 1'b0);
        wait_for_results();
    endtask

    // one key repeated so its count climbs well past the table size
    task automatic test_repeated_key();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        offer_key(8'h3C, 1'b1);
        repeat (64) offer_key(8'h3C, 1'b0);
        wait_for_results();
    endtask

    // long receiver hold-off while keys keep coming
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 300;
        offer_key(8'h11, 1'b1);
        for (int k = 0; k < 30; k++) offer_key(8'($urandom_range(4)), 1'b0);
        wait_for_results();
    endtask

    // streams of keys from small pools, each opened by a clear, with some noise
    task automatic test_random_streams(input int n_items, input int tx_pct,
                                       input int rx_pct);
        logic [dkc_pkg::KEY_IN_W-1:0] pool[$];
        int                           sent;
        int                           pool_size;
        int                           run_len;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent         = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                offer_key(8'($urandom), 1'($urandom_range(1)));
                sent++;
            end else begin
                pool_size = ($urandom_range(3) == 0) ? $urandom_range(17, 40)
                                                     : $urandom_range(1, 16);
                pool.delete();
                repeat (pool_size) pool.push_back(8'($urandom));
                run_len = $urandom_range(4, 60);
                for (int j = 0; j < run_len; j++) begin
                    offer_key(pool[$urandom_range(pool_size - 1)], j == 0);
                    sent++;
                end
            end
        end
        wait_for_results();
    endtask

    // test sequence
    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_key          <= '0;
        i_first        <= 1'b0;
        mismatch_count = 0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        hold_request   = 0;
        keys_held      = 0;
        foreach (key_counts[i]) key_counts[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random_streams(220, 0, 0);
        test_random_streams(220, 82, 0);
        test_random_streams(220, 0, 82);
        test_random_streams(220, 21, 21);
        test_repeated_key();

        repeat (16) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("** distinct_key_counter: PASSED **");
        end else begin
            $display("** distinct_key_counter: FAILED **");
        end
        $finish;
    end

endmodule
